>>> src/rrast_pkg.sv
// shared types, constants and helpers for the rectangle add/sum tree
package rrast_pkg;

  localparam int DEF_MAX_DIM = 64;
  localparam int COORD_W     = 7;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 1;
  localparam int AREA_W      = 2 * COORD_W;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_SUM   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [1:0] PH_ENTER = 2'd0;
  localparam logic [1:0] PH_LO    = 2'd1;
  localparam logic [1:0] PH_HI    = 2'd2;

  typedef struct packed {
    logic        [1:0]        kind;
    logic        [5:0]        row_first;
    logic        [5:0]        row_last;
    logic        [5:0]        col_first;
    logic        [5:0]        col_last;
    logic signed [DATA_W-1:0] amount;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] answer;
    logic                     answered;
  } out_rsp_t;

  typedef struct packed {
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic               axis;
  } rect_t;

  typedef struct packed {
    logic load_area;
    logic load_prod;
  } alu_ctrl_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NODE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_WLEAF,
    ST_PD_RD,
    ST_PD_CHK,
    ST_PD_CLR,
    ST_DESC,
    ST_AP_RD,
    ST_AP_MUL,
    ST_AP_WR,
    ST_PULL_A,
    ST_PULL_B,
    ST_PULL_WR,
    ST_POP,
    ST_RET,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RET_POP,
    RET_PD_HI,
    RET_PD_END
  } ret_e;

  function automatic logic split_rows(rect_t n);
    return (!n.axis || (n.left == n.right)) && (n.top < n.bottom);
  endfunction

  function automatic rect_t rect_lo(rect_t n);
    rect_t              r;
    logic [COORD_W:0]   s;
    r      = n;
    r.axis = ~n.axis;
    if (split_rows(n)) begin
      s        = {1'b0, n.top} + {1'b0, n.bottom};
      r.bottom = s[COORD_W:1];
    end else begin
      s       = {1'b0, n.left} + {1'b0, n.right};
      r.right = s[COORD_W:1];
    end
    return r;
  endfunction

  function automatic rect_t rect_hi(rect_t n);
    rect_t              r;
    logic [COORD_W:0]   s;
    r      = n;
    r.axis = ~n.axis;
    if (split_rows(n)) begin
      s     = {1'b0, n.top} + {1'b0, n.bottom};
      r.top = s[COORD_W:1] + 1'b1;
    end else begin
      s      = {1'b0, n.left} + {1'b0, n.right};
      r.left = s[COORD_W:1] + 1'b1;
    end
    return r;
  endfunction

  function automatic logic is_leaf(rect_t n);
    return (n.top == n.bottom) && (n.left == n.right);
  endfunction

endpackage

>>> src/rrast_ram.sv
// generic single write port, single read port ram with registered read
module rrast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> src/rrast_alu.sv
// shared area and scaled-add multiplier, two registered steps
module rrast_alu (
  input  logic                       clk_i,
  input  rrast_pkg::alu_ctrl_t       ctrl_i,
  input  rrast_pkg::rect_t           rect_i,
  input  logic [rrast_pkg::DATA_W-1:0] val_i,
  output logic [rrast_pkg::DATA_W-1:0] prod_o
);

  logic [rrast_pkg::COORD_W-1:0] h;
  logic [rrast_pkg::COORD_W-1:0] w;
  logic [rrast_pkg::AREA_W-1:0]  area_q;
  logic [rrast_pkg::AREA_W+rrast_pkg::DATA_W-1:0] full;

  assign h    = rect_i.bottom - rect_i.top + 1'b1;
  assign w    = rect_i.right - rect_i.left + 1'b1;
  assign full = (rrast_pkg::AREA_W + rrast_pkg::DATA_W)'(area_q)
              * (rrast_pkg::AREA_W + rrast_pkg::DATA_W)'(val_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_area) begin
      area_q <= rrast_pkg::AREA_W'(h) * rrast_pkg::AREA_W'(w);
    end
    if (ctrl_i.load_prod) begin
      prod_o <= full[rrast_pkg::DATA_W-1:0];
    end
  end

endmodule

>>> src/rect_range_add_sum_tree.sv
// top level: node store, traversal stack and sequencer of the rectangle tree
// per node: a covered sum reads and accumulates the total, a covered add reads,
//   multiplies and writes back, a push-down reads the pending value and, if nonzero,
//   applies it to both children and clears it, a pull-up adds both child totals; each
//   node ram has one read port; a stalled result holds the block in its done state
// one request at a time; reset and a register write while idle or clearing start a
//   clearing pass over all 2*P*P node slots (P = MAX_DIM rounded up to a power of two,
//   at least 2) during which no request is taken
module rect_range_add_sum_tree #(
  parameter int MAX_DIM = rrast_pkg::DEF_MAX_DIM
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rrast_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rrast_pkg::COORD_W-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rrast_pkg::in_req_t                  in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rrast_pkg::out_rsp_t                 out_rsp_o
);

  localparam int DIM_POW2    = (MAX_DIM <= 2) ? 2 : 2 ** $clog2(MAX_DIM);
  localparam int LOG_DIM     = $clog2(DIM_POW2);
  localparam int AW          = 2 * LOG_DIM + 1;
  localparam int NODE_SLOTS  = 2 ** AW;
  localparam int STACK_DEPTH = 2 * LOG_DIM + 1;
  localparam int PW          = $clog2(STACK_DEPTH);
  localparam int SPW         = $clog2(STACK_DEPTH + 1);
  localparam int CW          = rrast_pkg::COORD_W;
  localparam int DW          = rrast_pkg::DATA_W;
  localparam logic [CW-1:0] DIM_CAP = (MAX_DIM > 127) ? 7'd127 : CW'(MAX_DIM);
  localparam logic [CW-1:0] DIM_RST = (MAX_DIM < 64) ? CW'(MAX_DIM) : 7'd64;

  rrast_pkg::state_e state_q, state_d;

  rrast_pkg::in_req_t req_q;
  logic [CW-1:0]      rows_q, cols_q, cfg_val;
  logic [AW-1:0]      clr_cnt_q;
  logic [DW-1:0]      acc_q, tmp_q;

  logic [AW-1:0]          ap_idx_q;
  rrast_pkg::rect_t       ap_rect_q;
  logic [DW-1:0]          ap_val_q;
  rrast_pkg::ret_e        ap_ret_q;

  logic [SPW-1:0]         sp_q;
  logic [AW-1:0]          stk_idx_q  [STACK_DEPTH];
  rrast_pkg::rect_t       stk_rect_q [STACK_DEPTH];
  logic [1:0]             stk_ph_q   [STACK_DEPTH];
  logic [PW-1:0]          top_ptr;
  logic [AW-1:0]          t_idx, t_lo_idx, t_hi_idx;
  rrast_pkg::rect_t       t_rect, t_lo, t_hi, root, q_rect;
  logic [1:0]             t_ph;

  logic                   stk_init, stk_push, stk_pop, stk_set_ph;
  logic [AW-1:0]          push_idx;
  rrast_pkg::rect_t       push_rect;
  logic [1:0]             set_ph_val;

  logic                   tot_we, tot_re, pnd_we, pnd_re;
  logic [AW-1:0]          tot_waddr, tot_raddr, pnd_waddr, pnd_raddr;
  logic [DW-1:0]          tot_wdata, pnd_wdata, tot_rdata, pnd_rdata;

  rrast_pkg::alu_ctrl_t   alu_ctrl;
  logic [DW-1:0]          prod;

  logic accept, start_ok, out_free, disjoint, covers, t_leaf, go_lo;

  assign in_ready_o  = (state_q == rrast_pkg::ST_IDLE) && !cfg_we_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_o || out_ready_i;

  // register value clamped into the legal range
  always_comb begin
    cfg_val = cfg_wdata_i;
    if (cfg_val == '0) begin
      cfg_val = 7'd1;
    end else if (cfg_val > DIM_CAP) begin
      cfg_val = DIM_CAP;
    end
  end

  always_comb begin
    case (in_req_i.kind)
      rrast_pkg::KIND_WRITE: start_ok = ({1'b0, in_req_i.row_first} < rows_q)
                                     && ({1'b0, in_req_i.col_first} < cols_q);
      rrast_pkg::KIND_ADD,
      rrast_pkg::KIND_SUM:   start_ok = (in_req_i.row_first <= in_req_i.row_last)
                                     && (in_req_i.col_first <= in_req_i.col_last);
      default:               start_ok = 1'b0;
    endcase
  end

  assign root.top    = '0;
  assign root.bottom = rows_q - 1'b1;
  assign root.left   = '0;
  assign root.right  = cols_q - 1'b1;
  assign root.axis   = 1'b0;

  assign q_rect.top    = {1'b0, req_q.row_first};
  assign q_rect.bottom = {1'b0, req_q.row_last};
  assign q_rect.left   = {1'b0, req_q.col_first};
  assign q_rect.right  = {1'b0, req_q.col_last};
  assign q_rect.axis   = 1'b0;

  assign top_ptr  = PW'(sp_q - 1'b1);
  assign t_idx    = stk_idx_q[top_ptr];
  assign t_rect   = stk_rect_q[top_ptr];
  assign t_ph     = stk_ph_q[top_ptr];
  assign t_lo     = rrast_pkg::rect_lo(t_rect);
  assign t_hi     = rrast_pkg::rect_hi(t_rect);
  assign t_lo_idx = {t_idx[AW-2:0], 1'b0};
  assign t_hi_idx = {t_idx[AW-2:0], 1'b1};
  assign t_leaf   = rrast_pkg::is_leaf(t_rect);

  assign disjoint = (q_rect.top > t_rect.bottom) || (q_rect.bottom < t_rect.top)
                 || (q_rect.left > t_rect.right) || (q_rect.right < t_rect.left);
  assign covers   = (q_rect.top <= t_rect.top) && (q_rect.bottom >= t_rect.bottom)
                 && (q_rect.left <= t_rect.left) && (q_rect.right >= t_rect.right);
  assign go_lo    = (q_rect.top <= t_lo.bottom) && (q_rect.left <= t_lo.right);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrast_pkg::ST_CLEAR: begin
        if (!cfg_we_i && (&clr_cnt_q)) begin
          state_d = rrast_pkg::ST_IDLE;
        end
      end
      rrast_pkg::ST_IDLE: begin
        if (cfg_we_i) begin
          state_d = rrast_pkg::ST_CLEAR;
        end else if (accept) begin
          state_d = start_ok ? rrast_pkg::ST_NODE : rrast_pkg::ST_DONE;
        end
      end
      rrast_pkg::ST_NODE: begin
        if (req_q.kind == rrast_pkg::KIND_WRITE) begin
          state_d = t_leaf ? rrast_pkg::ST_WLEAF : rrast_pkg::ST_PD_RD;
        end else if (disjoint) begin
          state_d = rrast_pkg::ST_POP;
        end else if (covers) begin
          state_d = (req_q.kind == rrast_pkg::KIND_ADD) ? rrast_pkg::ST_AP_RD
                                                        : rrast_pkg::ST_SUM_RD;
        end else if (t_leaf) begin
          state_d = rrast_pkg::ST_POP;
        end else begin
          state_d = rrast_pkg::ST_PD_RD;
        end
      end
      rrast_pkg::ST_SUM_RD:  state_d = rrast_pkg::ST_SUM_ACC;
      rrast_pkg::ST_SUM_ACC: state_d = rrast_pkg::ST_POP;
      rrast_pkg::ST_WLEAF:   state_d = rrast_pkg::ST_POP;
      rrast_pkg::ST_PD_RD:   state_d = rrast_pkg::ST_PD_CHK;
      rrast_pkg::ST_PD_CHK: begin
        state_d = (pnd_rdata == '0) ? rrast_pkg::ST_DESC : rrast_pkg::ST_AP_RD;
      end
      rrast_pkg::ST_AP_RD:   state_d = rrast_pkg::ST_AP_MUL;
      rrast_pkg::ST_AP_MUL:  state_d = rrast_pkg::ST_AP_WR;
      rrast_pkg::ST_AP_WR: begin
        case (ap_ret_q)
          rrast_pkg::RET_PD_HI:  state_d = rrast_pkg::ST_AP_RD;
          rrast_pkg::RET_PD_END: state_d = rrast_pkg::ST_PD_CLR;
          default:               state_d = rrast_pkg::ST_POP;
        endcase
      end
      rrast_pkg::ST_PD_CLR:  state_d = rrast_pkg::ST_DESC;
      rrast_pkg::ST_DESC:    state_d = rrast_pkg::ST_NODE;
      rrast_pkg::ST_POP:     state_d = rrast_pkg::ST_RET;
      rrast_pkg::ST_RET: begin
        if (sp_q == '0) begin
          state_d = rrast_pkg::ST_DONE;
        end else if (t_ph == rrast_pkg::PH_LO) begin
          state_d = rrast_pkg::ST_NODE;
        end else if (req_q.kind == rrast_pkg::KIND_SUM) begin
          state_d = rrast_pkg::ST_POP;
        end else begin
          state_d = rrast_pkg::ST_PULL_A;
        end
      end
      rrast_pkg::ST_PULL_A:  state_d = rrast_pkg::ST_PULL_B;
      rrast_pkg::ST_PULL_B:  state_d = rrast_pkg::ST_PULL_WR;
      rrast_pkg::ST_PULL_WR: state_d = rrast_pkg::ST_POP;
      rrast_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rrast_pkg::ST_IDLE;
        end
      end
      default: state_d = rrast_pkg::ST_CLEAR;
    endcase
  end

  // memory, stack and multiplier controls
  always_comb begin
    tot_we     = 1'b0;
    tot_re     = 1'b0;
    pnd_we     = 1'b0;
    pnd_re     = 1'b0;
    tot_waddr  = t_idx;
    tot_raddr  = t_idx;
    pnd_waddr  = t_idx;
    pnd_raddr  = t_idx;
    tot_wdata  = '0;
    pnd_wdata  = '0;
    stk_init   = 1'b0;
    stk_push   = 1'b0;
    stk_pop    = 1'b0;
    stk_set_ph = 1'b0;
    push_idx   = t_lo_idx;
    push_rect  = t_lo;
    set_ph_val = rrast_pkg::PH_HI;
    alu_ctrl   = '0;
    case (state_q)
      rrast_pkg::ST_CLEAR: begin
        tot_we    = 1'b1;
        pnd_we    = 1'b1;
        tot_waddr = clr_cnt_q;
        pnd_waddr = clr_cnt_q;
      end
      rrast_pkg::ST_IDLE: begin
        stk_init = accept && start_ok && !cfg_we_i;
      end
      rrast_pkg::ST_SUM_RD: tot_re = 1'b1;
      rrast_pkg::ST_WLEAF: begin
        tot_we    = 1'b1;
        tot_wdata = req_q.amount;
      end
      rrast_pkg::ST_PD_RD: pnd_re = 1'b1;
      rrast_pkg::ST_AP_RD: begin
        tot_re             = 1'b1;
        pnd_re             = 1'b1;
        tot_raddr          = ap_idx_q;
        pnd_raddr          = ap_idx_q;
        alu_ctrl.load_area = 1'b1;
      end
      rrast_pkg::ST_AP_MUL: alu_ctrl.load_prod = 1'b1;
      rrast_pkg::ST_AP_WR: begin
        tot_we    = 1'b1;
        tot_waddr = ap_idx_q;
        tot_wdata = tot_rdata + prod;
        pnd_we    = !rrast_pkg::is_leaf(ap_rect_q);
        pnd_waddr = ap_idx_q;
        pnd_wdata = pnd_rdata + ap_val_q;
      end
      rrast_pkg::ST_PD_CLR: pnd_we = 1'b1;
      rrast_pkg::ST_DESC: begin
        stk_set_ph = 1'b1;
        stk_push   = 1'b1;
        if (req_q.kind == rrast_pkg::KIND_WRITE) begin
          set_ph_val = rrast_pkg::PH_HI;
          push_idx   = go_lo ? t_lo_idx : t_hi_idx;
          push_rect  = go_lo ? t_lo : t_hi;
        end else begin
          set_ph_val = rrast_pkg::PH_LO;
        end
      end
      rrast_pkg::ST_POP: stk_pop = 1'b1;
      rrast_pkg::ST_RET: begin
        if ((sp_q != '0) && (t_ph == rrast_pkg::PH_LO)) begin
          stk_set_ph = 1'b1;
          stk_push   = 1'b1;
          push_idx   = t_hi_idx;
          push_rect  = t_hi;
        end
      end
      rrast_pkg::ST_PULL_A: begin
        tot_re    = 1'b1;
        tot_raddr = t_lo_idx;
      end
      rrast_pkg::ST_PULL_B: begin
        tot_re    = 1'b1;
        tot_raddr = t_hi_idx;
      end
      rrast_pkg::ST_PULL_WR: begin
        tot_we    = 1'b1;
        tot_wdata = tmp_q + tot_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrast_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      rows_q      <= DIM_RST;
      cols_q      <= DIM_RST;
      sp_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        clr_cnt_q <= '0;
        case (cfg_idx_i)
          rrast_pkg::REG_ROWS: rows_q <= cfg_val;
          rrast_pkg::REG_COLS: cols_q <= cfg_val;
          default: ;
        endcase
      end else if (state_q == rrast_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (stk_init) begin
        sp_q <= SPW'(1);
      end else if (stk_push) begin
        sp_q <= sp_q + 1'b1;
      end else if (stk_pop) begin
        sp_q <= sp_q - 1'b1;
      end
      if ((state_q == rrast_pkg::ST_DONE) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // stack entries and datapath
  always_ff @(posedge clk_i) begin
    if (stk_init) begin
      stk_idx_q[0]  <= AW'(1);
      stk_rect_q[0] <= root;
      stk_ph_q[0]   <= rrast_pkg::PH_ENTER;
    end else begin
      if (stk_set_ph) begin
        stk_ph_q[top_ptr] <= set_ph_val;
      end
      if (stk_push) begin
        stk_idx_q[sp_q[PW-1:0]]  <= push_idx;
        stk_rect_q[sp_q[PW-1:0]] <= push_rect;
        stk_ph_q[sp_q[PW-1:0]]   <= rrast_pkg::PH_ENTER;
      end
    end
    if (accept) begin
      req_q <= in_req_i;
      acc_q <= '0;
    end
    if (state_q == rrast_pkg::ST_SUM_ACC) begin
      acc_q <= acc_q + tot_rdata;
    end
    if (state_q == rrast_pkg::ST_PULL_B) begin
      tmp_q <= tot_rdata;
    end
    if ((state_q == rrast_pkg::ST_NODE) && covers) begin
      ap_idx_q  <= t_idx;
      ap_rect_q <= t_rect;
      ap_val_q  <= req_q.amount;
      ap_ret_q  <= rrast_pkg::RET_POP;
    end else if (state_q == rrast_pkg::ST_PD_CHK) begin
      ap_idx_q  <= t_lo_idx;
      ap_rect_q <= t_lo;
      ap_val_q  <= pnd_rdata;
      ap_ret_q  <= rrast_pkg::RET_PD_HI;
    end else if ((state_q == rrast_pkg::ST_AP_WR) && (ap_ret_q == rrast_pkg::RET_PD_HI)) begin
      ap_idx_q  <= t_hi_idx;
      ap_rect_q <= t_hi;
      ap_ret_q  <= rrast_pkg::RET_PD_END;
    end
    if ((state_q == rrast_pkg::ST_DONE) && out_free) begin
      out_rsp_o.answered <= (req_q.kind == rrast_pkg::KIND_SUM);
      out_rsp_o.answer   <= (req_q.kind == rrast_pkg::KIND_SUM) ? acc_q : '0;
    end
  end

  rrast_ram #(
    .WIDTH (DW),
    .DEPTH (NODE_SLOTS)
  ) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .re_i    (tot_re),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  rrast_ram #(
    .WIDTH (DW),
    .DEPTH (NODE_SLOTS)
  ) u_pending_ram (
    .clk_i   (clk_i),
    .we_i    (pnd_we),
    .waddr_i (pnd_waddr),
    .wdata_i (pnd_wdata),
    .re_i    (pnd_re),
    .raddr_i (pnd_raddr),
    .rdata_o (pnd_rdata)
  );

  rrast_alu u_alu (
    .clk_i  (clk_i),
    .ctrl_i (alu_ctrl),
    .rect_i (ap_rect_q),
    .val_i  (ap_val_q),
    .prod_o (prod)
  );

endmodule
